@@ rtl/mhic_pkg.sv @@
// Package with the beat types, register indexes and reset constants of the calibrator.
`default_nettype none
package mhic_pkg;

  localparam int unsigned Axes       = 3;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [TimeBits-1:0] UpdatePeriodReset = 32'd100000;
  localparam logic [TimeBits-1:0] CalWindowReset    = 32'd10000000;

  typedef enum logic [CfgIdxBits-1:0] {
    RegSensorPresent = 2'd0,
    RegApplyOffset   = 2'd1,
    RegUpdatePeriod  = 2'd2,
    RegCalWindow     = 2'd3
  } cfg_reg_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic [TimeBits-1:0] now_us;
    sample_t             mag_x;
    sample_t             mag_y;
    sample_t             mag_z;
    logic                start_calibration;
  } in_beat_t;

  typedef struct packed {
    sample_t out_x;
    sample_t out_y;
    sample_t out_z;
    logic    calibrating;
    logic    calibration_done;
    sample_t offset_x_out;
    sample_t offset_y_out;
    sample_t offset_z_out;
  } out_beat_t;

endpackage
`default_nettype wire

@@ rtl/magnetometer_hard_iron_calibrator_top.sv @@
// Top level of the hard-iron calibrator: input register, update logic and result register.
//
// Channel  Direction  Handshake                  Beat
// in       input      in_valid_i / in_ready_o    mhic_pkg::in_beat_t
// out      output     out_valid_o / out_ready_i  mhic_pkg::out_beat_t
// cfg      input      cfg_valid_i / cfg_ready_o  index and 32-bit data
//
// An accepted input beat is held in the input register, and its result beat then in the result register; one beat
// is taken every cycle while the result register is empty or being read.
// Reset restores the register defaults and clears all calibration state.
// A stalled result holds the input register; ignored beats produce no result.
`default_nettype none
module magnetometer_hard_iron_calibrator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire mhic_pkg::in_beat_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output mhic_pkg::out_beat_t                     out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mhic_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [mhic_pkg::TimeBits-1:0]      cfg_data_i
);

  logic                              sensor_present_q;
  logic                              apply_offset_q;
  logic [mhic_pkg::TimeBits-1:0]     update_period_q;
  logic [mhic_pkg::TimeBits-1:0]     cal_window_q;

  logic                              in_vld_q;
  mhic_pkg::in_beat_t                in_q;
  logic                              out_vld_q, out_vld_d;
  mhic_pkg::out_beat_t               out_q, out_d;

  logic [mhic_pkg::TimeBits-1:0]     next_due_q, next_due_d;
  logic [mhic_pkg::TimeBits-1:0]     win_start_q, win_start_d;
  logic                              win_open_q, win_open_d;
  mhic_pkg::sample_t                 min_q [mhic_pkg::Axes];
  mhic_pkg::sample_t                 max_q [mhic_pkg::Axes];
  mhic_pkg::sample_t                 off_q [mhic_pkg::Axes];
  mhic_pkg::sample_t                 min_d [mhic_pkg::Axes];
  mhic_pkg::sample_t                 max_d [mhic_pkg::Axes];
  mhic_pkg::sample_t                 off_d [mhic_pkg::Axes];

  logic                              advance;
  logic                              fire;
  logic                              due;
  logic [mhic_pkg::TimeBits-1:0]     due_diff;
  logic [mhic_pkg::TimeBits-1:0]     win_diff;
  logic                              win_active;
  logic                              done;
  mhic_pkg::sample_t                 samp [mhic_pkg::Axes];
  mhic_pkg::sample_t                 corr [mhic_pkg::Axes];
  logic signed [mhic_pkg::SampleBits:0] sum [mhic_pkg::Axes];
  logic signed [mhic_pkg::SampleBits:0] half [mhic_pkg::Axes];

  assign advance     = !out_vld_q || out_ready_i;
  assign fire        = in_vld_q && advance;
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign samp[0] = in_q.mag_x;
  assign samp[1] = in_q.mag_y;
  assign samp[2] = in_q.mag_z;

  always_comb begin
    due_diff    = in_q.now_us - next_due_q;
    due         = sensor_present_q && !due_diff[mhic_pkg::TimeBits-1];
    next_due_d  = in_q.now_us + update_period_q;
    win_start_d = in_q.start_calibration ? next_due_d : win_start_q;
    win_diff    = in_q.start_calibration ? '0 : (next_due_d - win_start_q);
    win_active  = in_q.start_calibration || win_open_q;
    win_open_d  = win_active;
    done        = 1'b0;
    for (int a = 0; a < mhic_pkg::Axes; a++) begin
      min_d[a] = in_q.start_calibration ? samp[a] : min_q[a];
      max_d[a] = in_q.start_calibration ? samp[a] : max_q[a];
      off_d[a] = in_q.start_calibration ? '0 : off_q[a];
      corr[a]  = apply_offset_q ? mhic_pkg::sample_t'(samp[a] - off_d[a]) : samp[a];
      sum[a]   = {min_d[a][mhic_pkg::SampleBits-1], min_d[a]}
               + {max_d[a][mhic_pkg::SampleBits-1], max_d[a]};
      half[a]  = (sum[a] >>> 1)
               + {{mhic_pkg::SampleBits{1'b0}}, sum[a][mhic_pkg::SampleBits] & sum[a][0]};
    end
    if (win_active) begin
      if (win_diff < cal_window_q) begin
        for (int a = 0; a < mhic_pkg::Axes; a++) begin
          if (corr[a] < min_d[a]) begin
            min_d[a] = corr[a];
          end
          if (corr[a] > max_d[a]) begin
            max_d[a] = corr[a];
          end
        end
      end else begin
        win_open_d = 1'b0;
        done       = 1'b1;
        for (int a = 0; a < mhic_pkg::Axes; a++) begin
          off_d[a] = half[a][mhic_pkg::SampleBits-1:0];
        end
      end
    end
    out_d.out_x            = corr[0];
    out_d.out_y            = corr[1];
    out_d.out_z            = corr[2];
    out_d.calibrating      = win_open_d;
    out_d.calibration_done = done;
    out_d.offset_x_out     = off_d[0];
    out_d.offset_y_out     = off_d[1];
    out_d.offset_z_out     = off_d[2];
    if (fire && due) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_present_q <= 1'b1;
      apply_offset_q   <= 1'b0;
      update_period_q  <= mhic_pkg::UpdatePeriodReset;
      cal_window_q     <= mhic_pkg::CalWindowReset;
    end else if (cfg_valid_i) begin
      unique case (mhic_pkg::cfg_reg_e'(cfg_index_i))
        mhic_pkg::RegSensorPresent: sensor_present_q <= cfg_data_i[0];
        mhic_pkg::RegApplyOffset:   apply_offset_q   <= cfg_data_i[0];
        mhic_pkg::RegUpdatePeriod:  update_period_q  <= cfg_data_i;
        mhic_pkg::RegCalWindow:     cal_window_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire && due) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_due_q  <= '0;
      win_start_q <= '0;
      win_open_q  <= 1'b0;
      for (int a = 0; a < mhic_pkg::Axes; a++) begin
        min_q[a] <= '0;
        max_q[a] <= '0;
        off_q[a] <= '0;
      end
    end else if (fire && due) begin
      next_due_q  <= next_due_d;
      win_start_q <= win_start_d;
      win_open_q  <= win_open_d;
      for (int a = 0; a < mhic_pkg::Axes; a++) begin
        min_q[a] <= min_d[a];
        max_q[a] <= max_d[a];
        off_q[a] <= off_d[a];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mhic_checker.sv @@
// Port checker for the calibrator and its bind to the top level.
`default_nettype none
module mhic_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire mhic_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat changed while stalled.");

  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.calibration_done |-> !out_data_o.calibrating)
    else $error("Done beat reports an open window.");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("Result beat appeared without an accepted input beat.");

endmodule

bind magnetometer_hard_iron_calibrator_top mhic_checker u_mhic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
